FILE: hdl/jlk2_pkg.sv
`timescale 1ns / 1ps

package jlk2_pkg;

	localparam logic [31:0] GOLDEN_RATIO = 32'h9e3779b9;
	localparam logic [31:0] INIT_C       = 32'hfeedbeef;

	// byte position that closes a 12-byte block
	localparam logic [3:0] LAST_LANE_POS = 4'd11;

	localparam int unsigned JOB_DEPTH_DEF = 4;
	localparam int unsigned RES_DEPTH_DEF = 2;

	localparam logic [1:0] JOB_BLOCK       = 2'd0;
	localparam logic [1:0] JOB_FINAL       = 2'd1;
	localparam logic [1:0] JOB_BLOCK_FINAL = 2'd2;

	localparam logic [1:0] ROLE_A = 2'd0;
	localparam logic [1:0] ROLE_B = 2'd1;
	localparam logic [1:0] ROLE_C = 2'd2;

	localparam int unsigned MIX_STEPS = 9;

	localparam logic [1:0] MIX_ROLE [MIX_STEPS] = '{
		ROLE_A, ROLE_B, ROLE_C, ROLE_A, ROLE_B, ROLE_C, ROLE_A, ROLE_B, ROLE_C
	};
	localparam logic [4:0] MIX_SHIFT [MIX_STEPS] = '{
		5'd13, 5'd8, 5'd13, 5'd12, 5'd16, 5'd5, 5'd3, 5'd10, 5'd15
	};

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} abc_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] len;
	} job_t;

	// one line of the lookup2 mix
	function automatic abc_t mix_line(input logic [1:0] role, input logic [4:0] sh,
		input abc_t x);
		abc_t y;
		y = x;
		case (role)
			ROLE_A: begin
				y.a = (x.a - x.b - x.c) ^ (x.c >> sh);
			end
			ROLE_B: begin
				y.b = (x.b - x.c - x.a) ^ (x.a << sh);
			end
			ROLE_C: begin
				y.c = (x.c - x.a - x.b) ^ (x.b >> sh);
			end
			default: begin
				y = x;
			end
		endcase
		return y;
	endfunction

endpackage

FILE: hdl/jlk2_fifo.sv
`timescale 1ns / 1ps

module jlk2_fifo #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = jlk2_pkg::RES_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: hdl/jlk2_front.sv
`timescale 1ns / 1ps

module jlk2_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output logic             full,
	output logic             job_push,
	output jlk2_pkg::job_t   job,
	input  logic             job_full
);

	logic [31:0] acc_a_q;
	logic [31:0] acc_b_q;
	logic [23:0] acc_c_q;
	logic [3:0]  pos_q;
	logic [31:0] len_q;   // length including the byte now offered

	logic        accept;
	logic        blk_end;
	logic [31:0] lane32;
	logic [23:0] lane24;
	logic [31:0] a_n;
	logic [31:0] b_n;
	logic [23:0] c_n;

	assign full    = job_full;
	assign accept  = push & ~job_full;
	assign blk_end = (pos_q >= jlk2_pkg::LAST_LANE_POS);
	assign lane32  = {24'd0, data_byte} << {pos_q[1:0], 3'b000};
	assign lane24  = {16'd0, data_byte} << {pos_q[1:0], 3'b000};

	always_comb begin
		a_n = acc_a_q;
		b_n = acc_b_q;
		c_n = acc_c_q;
		if (pos_q < 4'd4) begin
			a_n = acc_a_q | lane32;
		end else if (pos_q < 4'd8) begin
			b_n = acc_b_q | lane32;
		end else if (!blk_end) begin
			c_n = acc_c_q | lane24;
		end
	end

	always_comb begin
		job.len = len_q;
		if (blk_end) begin
			job.kind = last_byte ? jlk2_pkg::JOB_BLOCK_FINAL : jlk2_pkg::JOB_BLOCK;
			job.a    = acc_a_q;
			job.b    = acc_b_q;
			job.c    = {data_byte, acc_c_q};
		end else begin
			job.kind = jlk2_pkg::JOB_FINAL;
			job.a    = a_n;
			job.b    = b_n;
			job.c    = {c_n, 8'd0} + len_q;
		end
	end

	assign job_push = accept & (blk_end | last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_a_q <= '0;
			acc_b_q <= '0;
			acc_c_q <= '0;
			pos_q   <= '0;
			len_q   <= 32'd1;
		end else if (accept) begin
			len_q <= last_byte ? 32'd1 : len_q + 32'd1;
			if (blk_end || last_byte) begin
				acc_a_q <= '0;
				acc_b_q <= '0;
				acc_c_q <= '0;
				pos_q   <= '0;
			end else begin
				acc_a_q <= a_n;
				acc_b_q <= b_n;
				acc_c_q <= c_n;
				pos_q   <= pos_q + 4'd1;
			end
		end
	end

endmodule

FILE: hdl/jlk2_back.sv
`timescale 1ns / 1ps

module jlk2_back (
	input  logic             clk,
	input  logic             arst_n,
	input  jlk2_pkg::job_t   job,
	input  logic             job_empty,
	output logic             job_pop,
	output logic             res_push,
	output logic [31:0]      res_hash,
	input  logic             res_full
);

	localparam int unsigned NSTG = jlk2_pkg::MIX_STEPS + 1;

	jlk2_pkg::abc_t chain_q;
	logic           busy_q;   // block mix in flight
	logic           half_q;   // block pass of a block+final request issued

	logic           valid_s [NSTG];
	logic           fin_s   [NSTG];
	jlk2_pkg::abc_t abc_s   [NSTG];

	logic           advance;
	logic           can_issue;
	logic           second;
	logic           issue_fin;
	jlk2_pkg::abc_t adds;
	logic           exit_blk;
	logic [NSTG-1:0] blk_vec;

	assign advance   = ~(valid_s[NSTG-1] & fin_s[NSTG-1] & res_full);
	assign can_issue = ~job_empty & ~busy_q & advance;
	assign second    = (job.kind == jlk2_pkg::JOB_BLOCK_FINAL) & half_q;
	assign issue_fin = (job.kind == jlk2_pkg::JOB_FINAL) | second;
	assign job_pop   = can_issue & ((job.kind != jlk2_pkg::JOB_BLOCK_FINAL) | half_q);
	assign exit_blk  = valid_s[NSTG-1] & ~fin_s[NSTG-1] & advance;

	always_comb begin
		if (second) begin
			adds.a = '0;
			adds.b = '0;
			adds.c = job.len;
		end else begin
			adds.a = job.a;
			adds.b = job.b;
			adds.c = job.c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q.a <= jlk2_pkg::GOLDEN_RATIO;
			chain_q.b <= jlk2_pkg::GOLDEN_RATIO;
			chain_q.c <= jlk2_pkg::INIT_C;
			busy_q    <= 1'b0;
			half_q    <= 1'b0;
		end else begin
			if (exit_blk) begin
				chain_q <= abc_s[NSTG-1];
				busy_q  <= 1'b0;
			end else if (can_issue && issue_fin) begin
				chain_q.a <= jlk2_pkg::GOLDEN_RATIO;
				chain_q.b <= jlk2_pkg::GOLDEN_RATIO;
				chain_q.c <= jlk2_pkg::INIT_C;
			end else if (can_issue) begin
				busy_q <= 1'b1;
			end
			if (can_issue && job.kind == jlk2_pkg::JOB_BLOCK_FINAL) begin
				half_q <= ~half_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NSTG; k++) begin
				valid_s[k] <= 1'b0;
				fin_s[k]   <= 1'b0;
			end
		end else if (advance) begin
			valid_s[0] <= can_issue;
			fin_s[0]   <= issue_fin;
			for (int k = 1; k < NSTG; k++) begin
				valid_s[k] <= valid_s[k-1];
				fin_s[k]   <= fin_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			abc_s[0].a <= chain_q.a + adds.a;
			abc_s[0].b <= chain_q.b + adds.b;
			abc_s[0].c <= chain_q.c + adds.c;
			for (int k = 1; k < NSTG; k++) begin
				abc_s[k] <= jlk2_pkg::mix_line(jlk2_pkg::MIX_ROLE[k-1],
					jlk2_pkg::MIX_SHIFT[k-1], abc_s[k-1]);
			end
		end
	end

	assign res_push = valid_s[NSTG-1] & fin_s[NSTG-1] & ~res_full;
	assign res_hash = abc_s[NSTG-1].c;

	always_comb begin
		for (int k = 0; k < NSTG; k++) begin
			blk_vec[k] = valid_s[k] & ~fin_s[k];
		end
	end

	a_one_block_mix: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(blk_vec) <= 1)
		else $error("more than one block mix in flight");

	a_busy_tracks_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (|blk_vec))
		else $error("busy flag out of step with the mix pipeline");

	a_half_head: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> (!job_empty && job.kind == jlk2_pkg::JOB_BLOCK_FINAL))
		else $error("half-issued request lost from the queue head");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(abc_s[NSTG-1]))
		else $error("stalled result changed");

endmodule

FILE: hdl/jenkins_lookup2_hash_unit.sv
// A final request waits while a block mix of the same message is still in the 10-stage
// mix pipeline, and a result can also wait on the job queue, result queue and output.
// Throughput: one byte per cycle while the job queue is not full; a final request enters
// the mix pipeline every cycle unless the result queue stalls it or a block mix holds it.
// Reset: arst_n clears both queues and restarts the hash state with no message open.
`timescale 1ns / 1ps

module jenkins_lookup2_hash_unit #(
	parameter int unsigned JOB_DEPTH = jlk2_pkg::JOB_DEPTH_DEF,
	parameter int unsigned RES_DEPTH = jlk2_pkg::RES_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] hash_value
);

	localparam int unsigned JOB_W = $bits(jlk2_pkg::job_t);

	jlk2_pkg::job_t   job_in;
	jlk2_pkg::job_t   job_head;
	logic [JOB_W-1:0] job_rd;
	logic             job_push;
	logic             job_full;
	logic             job_pop;
	logic             job_empty;
	logic             res_push;
	logic [31:0]      res_hash;
	logic             res_full;

	jlk2_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.full      (full),
		.job_push  (job_push),
		.job       (job_in),
		.job_full  (job_full)
	);

	jlk2_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (JOB_DEPTH)
	) u_job_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.wr_data (job_in),
		.full    (job_full),
		.pop     (job_pop),
		.rd_data (job_rd),
		.empty   (job_empty)
	);

	assign job_head = jlk2_pkg::job_t'(job_rd);

	jlk2_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_head),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.res_push  (res_push),
		.res_hash  (res_hash),
		.res_full  (res_full)
	);

	jlk2_fifo #(
		.WIDTH (32),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_hash),
		.full    (res_full),
		.pop     (pop),
		.rd_data (hash_value),
		.empty   (empty)
	);

endmodule
